### rtl/smdr_pkg.sv
// ----------------------------------------------------------------------------
// smdr_pkg
// shared types and constants of the sensor matrix debounce and remap block
// ----------------------------------------------------------------------------
package smdr_pkg;

  localparam int unsigned COORD_W     = 3;
  localparam int unsigned MAP_W       = 24;
  localparam int unsigned DEBOUNCE_W  = 16;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [MAP_W-1:0]      IDENTITY_MAP   = 24'd16434824;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 4'd0,
    CFG_SWAP_AXES     = 4'd1,
    CFG_ROW_MAP       = 4'd2,
    CFG_COL_MAP       = 4'd3
  } cfg_reg_e;

  function automatic coord_t map_entry(logic [MAP_W-1:0] tbl, coord_t idx);
    return tbl[COORD_W*idx +: COORD_W];
  endfunction

endpackage

### rtl/sensor_matrix_debounce_remap.sv
// ----------------------------------------------------------------------------
// sensor_matrix_debounce_remap
// per-cell debounce of a sensor matrix with row/column remapping
// ----------------------------------------------------------------------------
// One sample is taken per clock while in_stall_o is low; its result passes the
// input register and then the result register: the input register holds the
// remapped cell and the registered read of the change stamp memory, the result
// register holds the debounced state. A stamp write that meets a read of the same
// cell is forwarded, so samples of one cell may follow each other in consecutive
// cycles. Stable, raw and stamp-valid bits are flip-flops cleared by reset;
// there is no clearing pass. A result held by out_stall_i stalls the input only
// once the input register is full as well.
module sensor_matrix_debounce_remap #(
  parameter int unsigned ROWS      = 8,
  parameter int unsigned COLS      = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smdr_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smdr_pkg::COORD_W-1:0] phys_row_i,
  input  logic [smdr_pkg::COORD_W-1:0] phys_col_i,
  input  logic                        reading_i,
  input  logic [31:0]                 now_ms_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smdr_pkg::COORD_W-1:0] logical_row_o,
  output logic [smdr_pkg::COORD_W-1:0] logical_col_o,
  output logic                        stable_value_o,
  output logic                        changed_o
);
  import smdr_pkg::*;

  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned CELL_W = $clog2(CELLS);

  // configuration
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic                  swap_q;
  logic [MAP_W-1:0]      row_map_q;
  logic [MAP_W-1:0]      col_map_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      swap_q     <= 1'b0;
      row_map_q  <= IDENTITY_MAP;
      col_map_q  <= IDENTITY_MAP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_TIME: debounce_q <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_SWAP_AXES:     swap_q     <= cfg_data_i[0];
        CFG_ROW_MAP:       row_map_q  <= cfg_data_i[MAP_W-1:0];
        CFG_COL_MAP:       col_map_q  <= cfg_data_i[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic out_acc;

  assign out_acc    = out_valid_o && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // remap
  coord_t            lr_in;
  coord_t            lc_in;
  logic              range_in;
  logic [CELL_W-1:0] cell_in;

  always_comb begin
    lr_in    = map_entry(row_map_q, swap_q ? phys_col_i : phys_row_i);
    lc_in    = map_entry(col_map_q, swap_q ? phys_row_i : phys_col_i);
    range_in = (32'(lr_in) < ROWS) && (32'(lc_in) < COLS);
    cell_in  = CELL_W'(32'(lr_in) * COLS + 32'(lc_in));
  end

  // input register
  coord_t               lr_q;
  coord_t               lc_q;
  logic                 range_q;
  logic [CELL_W-1:0]    cell_q;
  logic                 reading_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] stamp_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lr_q      <= lr_in;
      lc_q      <= lc_in;
      range_q   <= range_in;
      cell_q    <= cell_in;
      reading_q <= reading_i;
      now_q     <= now_ms_i[TIME_BITS-1:0];
    end
  end

  // cell state
  logic [CELLS-1:0]     stable_q;
  logic [CELLS-1:0]     raw_q;
  logic [CELLS-1:0]     stamp_vld_q;
  logic [TIME_BITS-1:0] stamp_mem [CELLS];

  logic                 cur_stable;
  logic                 cur_raw;
  logic [TIME_BITS-1:0] cur_stamp;
  logic [TIME_BITS-1:0] age;
  logic                 settle;
  logic                 flip;
  logic                 new_stable;
  logic                 upd;
  logic                 wr_en;

  always_comb begin
    cur_stable = stable_q[cell_q];
    cur_raw    = raw_q[cell_q];
    cur_stamp  = stamp_vld_q[cell_q] ? stamp_rd_q : '0;
    age        = now_q - cur_stamp;
    settle     = (reading_q != cur_stable) && (reading_q == cur_raw);
    flip       = range_q && settle && (age >= TIME_BITS'(debounce_q));
    new_stable = flip ? reading_q : cur_stable;
    upd        = s1_adv && range_q;
    wr_en      = upd && !settle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= '0;
      raw_q       <= '0;
      stamp_vld_q <= '0;
    end else if (upd) begin
      raw_q[cell_q]    <= reading_q;
      stable_q[cell_q] <= new_stable;
      if (wr_en) begin
        stamp_vld_q[cell_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[cell_q] <= now_q;
    end
  end

  // registered read with forwarding of a write to the same cell
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (wr_en && (cell_q == cell_in)) begin
        stamp_rd_q <= now_q;
      end else begin
        stamp_rd_q <= stamp_mem[cell_in];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (out_acc) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      logical_row_o  <= lr_q;
      logical_col_o  <= lc_q;
      stable_value_o <= range_q && new_stable;
      changed_o      <= flip;
    end
  end

  // assertions
  a_raw_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> raw_q[$past(cell_q)] == $past(reading_q))
    else $error("raw bit did not take the reading");

  a_stamp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> stamp_vld_q[$past(cell_q)])
    else $error("stamp valid bit not set after write");

  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wr_en && (cell_q == cell_in)) |=> stamp_rd_q == $past(now_q))
    else $error("stamp write not forwarded to same-cell read");

  a_changed_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && changed_o && $past(s1_adv)) |->
      (stable_value_o == stable_q[$past(cell_q)]))
    else $error("changed result does not match stored stable bit");

endmodule
